>>> hw/rtl/ght_pkg.sv
// Package for the handle table: field widths, action codes, slot layout, control structs.
`timescale 1ns / 1ps
package ght_pkg;

    localparam int ACT_W     = 3;
    localparam int WORD_W    = 32;
    localparam int CNT_W     = 12;
    localparam int IDX_W     = 20;
    localparam int SLOTS_DEF = 1024;

    typedef enum logic [ACT_W-1:0] {
        ACT_CREATE = 3'd0,
        ACT_CLOSE  = 3'd1,
        ACT_GET    = 3'd2,
        ACT_SET    = 3'd3,
        ACT_CHECK  = 3'd4
    } t_action;

    // One table entry as stored in the RAM.
    typedef struct packed {
        logic              live;
        logic [CNT_W-1:0]  cnt;
        logic [WORD_W-1:0] word;
    } t_slot;

    typedef struct packed {
        logic clr_wr;   // write one reset entry, advance sweep
        logic accept;   // request word taken this cycle
        logic exec;     // read data back: decide, write, load result
    } t_ctrl_cmd;

    typedef struct packed {
        logic clr_last; // sweep is at the last entry
    } t_ctrl_sts;

endpackage

>>> hw/rtl/ght_if.sv
// Request and response channel interfaces of the handle table.
`timescale 1ns / 1ps
interface ght_req_if import ght_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [ACT_W-1:0]  action;
    logic [WORD_W-1:0] handle_in;
    logic [WORD_W-1:0] user_word;

    modport source (output valid, action, handle_in, user_word, input ready);
    modport sink   (input valid, action, handle_in, user_word, output ready);
endinterface

interface ght_rsp_if import ght_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [WORD_W-1:0] handle_out;
    logic [WORD_W-1:0] data_out;
    logic              success;

    modport source (output valid, handle_out, data_out, success, input ready);
    modport sink   (input valid, handle_out, data_out, success, output ready);
endinterface

>>> hw/rtl/generational_handle_table_unit.sv
// Top level of the generational handle table: controller, datapath, checks.
//
//  channel  dir  modport  fields
//  i_req    in   sink     action[2:0], handle_in[31:0], user_word[31:0]
//  o_rsp    out  source   handle_out[31:0], data_out[31:0], success
//
// Each word is accepted with the RAM read issued, then executed with write-back
// and the result register loaded, since the RAM read data is registered.
// After reset a sweep writes all SLOTS entries (1024 by default), one a cycle;
// i_req.ready stays low until it is done.
// A new word is taken while a result waits only if o_rsp.ready is high then.
`timescale 1ns / 1ps
module generational_handle_table_unit import ght_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic i_clk,
    input  logic i_rst_n,
    ght_req_if.sink   i_req,
    ght_rsp_if.source o_rsp
);

    t_ctrl_cmd cmd;
    t_ctrl_sts sts;

    ght_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_req.valid),
        .i_out_ready (o_rsp.ready),
        .i_sts       (sts),
        .o_in_ready  (i_req.ready),
        .o_out_valid (o_rsp.valid),
        .o_cmd       (cmd)
    );

    ght_dp #(
        .SLOTS (SLOTS)
    ) u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cmd        (cmd),
        .o_sts        (sts),
        .i_action     (i_req.action),
        .i_handle_in  (i_req.handle_in),
        .i_user_word  (i_req.user_word),
        .o_handle_out (o_rsp.handle_out),
        .o_data_out   (o_rsp.data_out),
        .o_success    (o_rsp.success)
    );

    // a rising valid follows an accepted request through the execute state
    a_rsp_after_req: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> $past(i_req.valid && i_req.ready, 2))
        else $error("result word without a preceding request");

    a_no_req_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.clr_wr |-> !i_req.ready)
        else $error("request taken during reset sweep");

    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req.valid && i_req.ready) |=> (!i_req.ready && cmd.exec))
        else $error("second request taken while one executes");

endmodule

>>> hw/rtl/ght_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module ght_ram #(
    parameter int W     = 32,
    parameter int DEPTH = 1024
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> hw/rtl/ght_ctrl.sv
// Controller: reset sweep, request accept, execute, result word valid.
`timescale 1ns / 1ps
module ght_ctrl import ght_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  logic      i_out_ready,
    input  t_ctrl_sts i_sts,
    output logic      o_in_ready,
    output logic      o_out_valid,
    output t_ctrl_cmd o_cmd
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   in_ready;
    logic   accept;

    // result register is free now or drained at this edge
    assign in_ready = (r_state == S_IDLE) && (!r_out_valid || i_out_ready);
    assign accept   = in_ready && i_in_valid;

    always_comb begin
        n_state     = r_state;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_CLEAR: begin
                if (i_sts.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (accept) begin
                    n_state = S_EXEC;
                end
            end
            S_EXEC: begin
                n_out_valid = 1'b1;
                n_state     = S_IDLE;
            end
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready    = in_ready;
    assign o_out_valid   = r_out_valid;
    assign o_cmd.clr_wr  = (r_state == S_CLEAR);
    assign o_cmd.accept  = accept;
    assign o_cmd.exec    = (r_state == S_EXEC);

endmodule

>>> hw/rtl/ght_dp.sv
// Datapath: slot RAM, free-list head, handle check, result registers.
`timescale 1ns / 1ps
module ght_dp import ght_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_ctrl_cmd         i_cmd,
    output t_ctrl_sts         o_sts,
    input  logic [ACT_W-1:0]  i_action,
    input  logic [WORD_W-1:0] i_handle_in,
    input  logic [WORD_W-1:0] i_user_word,
    output logic [WORD_W-1:0] o_handle_out,
    output logic [WORD_W-1:0] o_data_out,
    output logic              o_success
);

    localparam int IW = $clog2(SLOTS);
    localparam int HW = $clog2(SLOTS + 1);
    localparam logic [IDX_W:0] SLOTS_X = (IDX_W + 1)'(SLOTS);

    logic [HW-1:0]     r_head, n_head;
    logic [IW-1:0]     r_clr_idx;
    logic [ACT_W-1:0]  r_act;
    logic [WORD_W-1:0] r_h;
    logic [WORD_W-1:0] r_uw;
    logic [IW-1:0]     r_addr;
    logic [WORD_W-1:0] r_hout, n_hout;
    logic [WORD_W-1:0] r_dout, n_dout;
    logic              r_ok, n_ok;

    logic [IW-1:0]     raddr;
    logic [IW-1:0]     waddr;
    logic              we, x_we;
    t_slot             wdata, x_wdata, rd;
    logic [IDX_W-1:0]  h_idx;
    logic [CNT_W-1:0]  h_cnt;
    logic              h_ok;
    logic              full;
    logic [CNT_W-1:0]  cnt_inc;

    assign raddr = (i_action == ACT_CREATE) ? r_head[IW-1:0] : i_handle_in[IW-1:0];

    ght_ram #(
        .W     ($bits(t_slot)),
        .DEPTH (SLOTS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rd)
    );

    assign h_idx   = r_h[IDX_W-1:0];
    assign h_cnt   = r_h[WORD_W-1:IDX_W];
    assign h_ok    = (h_idx != '0) && ({1'b0, h_idx} < SLOTS_X) && rd.live && (rd.cnt == h_cnt);
    assign full    = (r_head == '0) || ({{(IDX_W + 1 - HW){1'b0}}, r_head} >= SLOTS_X);
    assign cnt_inc = rd.cnt + CNT_W'(1);

    always_comb begin
        n_head  = r_head;
        n_hout  = '0;
        n_dout  = '0;
        n_ok    = 1'b0;
        x_we    = 1'b0;
        x_wdata = rd;
        case (r_act)
            ACT_CREATE: begin
                if (!full) begin
                    x_we         = 1'b1;
                    x_wdata.live = 1'b1;
                    x_wdata.cnt  = cnt_inc;
                    x_wdata.word = r_uw;
                    n_head       = HW'(rd.word);
                    n_hout       = {cnt_inc, IDX_W'(r_head)};
                    n_ok         = 1'b1;
                end
            end
            ACT_CLOSE: begin
                if (h_ok) begin
                    x_we         = 1'b1;
                    x_wdata.live = 1'b0;
                    x_wdata.word = WORD_W'(r_head);
                    n_head       = HW'(h_idx);
                    n_ok         = 1'b1;
                end
            end
            ACT_GET: begin
                n_ok   = h_ok;
                n_dout = h_ok ? rd.word : '0;
            end
            ACT_SET: begin
                if (h_ok) begin
                    x_we         = 1'b1;
                    x_wdata.word = r_uw;
                    n_ok         = 1'b1;
                end
            end
            ACT_CHECK: begin
                n_ok = h_ok;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // reset sweep: each entry free, linked to the next
    assign we    = i_cmd.clr_wr || (i_cmd.exec && x_we);
    assign waddr = i_cmd.clr_wr ? r_clr_idx : r_addr;
    always_comb begin
        if (i_cmd.clr_wr) begin
            wdata.live = 1'b0;
            wdata.cnt  = '0;
            wdata.word = WORD_W'(r_clr_idx) + WORD_W'(1);
        end else begin
            wdata = x_wdata;
        end
    end

    assign o_sts.clr_last = (r_clr_idx == IW'(SLOTS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head    <= HW'(1);
            r_clr_idx <= '0;
        end else begin
            if (i_cmd.clr_wr) begin
                r_clr_idx <= r_clr_idx + IW'(1);
            end
            if (i_cmd.exec) begin
                r_head <= n_head;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_act  <= i_action;
            r_h    <= i_handle_in;
            r_uw   <= i_user_word;
            r_addr <= raddr;
        end
        if (i_cmd.exec) begin
            r_hout <= n_hout;
            r_dout <= n_dout;
            r_ok   <= n_ok;
        end
    end

    assign o_handle_out = r_hout;
    assign o_data_out   = r_dout;
    assign o_success    = r_ok;

endmodule

>>> tb/handle_table_checker.sv
// Handle table checker: watches both channels, predicts every reply and compares it.
`timescale 1ns / 1ps
module handle_table_checker import ght_pkg::*; #(
    parameter int SLOTS = SLOTS_DEF
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ght_req_if        i_req,
    ght_rsp_if        i_rsp,
    output int        o_fail_count,
    output int        o_pending
);

    typedef struct packed {
        logic [WORD_W-1:0] handle;
        logic [WORD_W-1:0] data;
        logic              ok;
    } t_reply;

    logic [CNT_W-1:0]  slot_count [SLOTS];
    logic              slot_live  [SLOTS];
    logic [WORD_W-1:0] slot_word  [SLOTS];
    logic [WORD_W-1:0] free_head;

    t_reply replies_due[$];

    initial begin
        o_fail_count = 0;
        o_pending    = 0;
    end

    function automatic bit handle_live(input logic [WORD_W-1:0] h);
        logic [IDX_W-1:0] idx;
        idx = h[IDX_W-1:0];
        if (idx == 0 || idx >= SLOTS) return 1'b0;
        return slot_live[idx] && (slot_count[idx] == h[WORD_W-1 -: CNT_W]);
    endfunction

    // Applies one request word to the shadow table and returns the reply it must produce.
    function automatic t_reply table_apply(input logic [ACT_W-1:0] act,
                                           input logic [WORD_W-1:0] h,
                                           input logic [WORD_W-1:0] uw);
        t_reply           r;
        logic [IDX_W-1:0] idx;
        logic [CNT_W-1:0] cnt;
        r   = '0;
        idx = h[IDX_W-1:0];
        if (act == ACT_CREATE) begin
            if (free_head != 0 && free_head < SLOTS) begin
                idx            = free_head[IDX_W-1:0];
                cnt            = slot_count[idx] + 1'b1;
                free_head      = slot_word[idx];  // link of a free slot
                slot_count[idx] = cnt;
                slot_live[idx]  = 1'b1;
                slot_word[idx]  = uw;
                r.handle       = {cnt, idx};
                r.ok           = 1'b1;
            end
        end else if (act >= ACT_CLOSE && act <= ACT_CHECK) begin
            if (handle_live(h)) begin
                r.ok = 1'b1;
                case (act)
                    ACT_CLOSE: begin
                        slot_live[idx] = 1'b0;
                        slot_word[idx] = free_head;
                        free_head      = WORD_W'(idx);
                    end
                    ACT_GET: begin
                        r.data = slot_word[idx];
                    end
                    ACT_SET: begin
                        slot_word[idx] = uw;
                    end
                    default: ;
                endcase
            end
        end
        return r;
    endfunction

    always @(posedge i_clk) begin
        t_reply want;
        if (!i_rst_n) begin
            for (int k = 0; k < SLOTS; k++) begin
                slot_count[k] = '0;
                slot_live[k]  = 1'b0;
                slot_word[k]  = WORD_W'(k + 1);
            end
            free_head = 1;
            replies_due.delete();
            o_pending = 0;
        end else begin
            // reply first: a word taken at this edge cannot be answered at the same edge
            if (i_rsp.valid && i_rsp.ready) begin
                if (replies_due.size() == 0) begin
                    $display("%0t: reply word with nothing pending: handle %h data %h ok %b",
                             $time, i_rsp.handle_out, i_rsp.data_out, i_rsp.success);
                    o_fail_count++;
                end else begin
                    want = replies_due.pop_front();
                    if (i_rsp.handle_out !== want.handle) begin
                        $display("%0t: handle_out expected %h, actual %h",
                                 $time, want.handle, i_rsp.handle_out);
                        o_fail_count++;
                    end
                    if (i_rsp.data_out !== want.data) begin
                        $display("%0t: data_out expected %h, actual %h",
                                 $time, want.data, i_rsp.data_out);
                        o_fail_count++;
                    end
                    if (i_rsp.success !== want.ok) begin
                        $display("%0t: success expected %b, actual %b",
                                 $time, want.ok, i_rsp.success);
                        o_fail_count++;
                    end
                end
            end
            if (i_req.valid && i_req.ready)
                replies_due.push_back(table_apply(i_req.action, i_req.handle_in,
                                                  i_req.user_word));
            o_pending = replies_due.size();
        end
    end

endmodule

>>> tb/testbench.sv
// Testbench top: clock, reset, request traffic in bursts, reply stalls, watchdog and verdict.
`timescale 1ns / 1ps
module testbench;
    import ght_pkg::*;

    localparam int SLOTS        = SLOTS_DEF;
    localparam int HALF_PERIOD  = 5;
    localparam int RESET_CYCLES = 6;
    localparam int IDLE_LIMIT   = 5000;  // covers the clearing sweep after reset
    localparam int DRAIN_CYCLES = 8;
    localparam int DEAD_KEEP    = 64;

    localparam logic [ACT_W-1:0] ACT_RSVD_FIRST = 3'd5;
    localparam logic [ACT_W-1:0] ACT_RSVD_LAST  = 3'd7;

    logic i_clk = 1'b0;
    logic i_rst_n;
    int   fail_count;
    int   table_pending;
    int   idle_cycles = 0;
    int   burst_left  = 0;
    int   stall_mode  = 0;
    int   mode_left   = 0;
    int   hold_left   = 0;

    logic [WORD_W-1:0] live_handles[$];
    logic [WORD_W-1:0] dead_handles[$];

    ght_req_if req_ch ();
    ght_rsp_if rsp_ch ();

    generational_handle_table_unit #(.SLOTS(SLOTS)) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch),
        .o_rsp   (rsp_ch)
    );

    handle_table_checker #(.SLOTS(SLOTS)) reply_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_req        (req_ch),
        .i_rsp        (rsp_ch),
        .o_fail_count (fail_count),
        .o_pending    (table_pending)
    );

    always #HALF_PERIOD i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
            idle_cycles = 0;
        end else begin
            idle_cycles++;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Handles handed out by successful creates feed the stimulus.
    always @(posedge i_clk) begin
        if (i_rst_n && rsp_ch.valid && rsp_ch.ready && rsp_ch.success
            && rsp_ch.handle_out != '0)
            live_handles.push_back(rsp_ch.handle_out);
    end

    // Reply side: phases of always ready, random ready, and runs of stalls.
    always @(negedge i_clk) begin
        if (mode_left == 0) begin
            stall_mode = $urandom_range(0, 2);
            mode_left  = $urandom_range(40, 160);
        end else begin
            mode_left--;
        end
        case (stall_mode)
            0: rsp_ch.ready <= 1'b1;
            1: rsp_ch.ready <= ($urandom_range(0, 9) < 7);
            default: begin
                if (hold_left > 0) begin
                    hold_left--;
                    rsp_ch.ready <= 1'b0;
                end else if ($urandom_range(0, 5) == 0) begin
                    hold_left = $urandom_range(1, 12);
                    rsp_ch.ready <= 1'b0;
                end else begin
                    rsp_ch.ready <= 1'b1;
                end
            end
        endcase
    end

    function automatic logic [WORD_W-1:0] make_handle(input int cnt, input int idx);
        return {CNT_W'(cnt), IDX_W'(idx)};
    endfunction

    function automatic logic [WORD_W-1:0] noise_handle();
        logic [WORD_W-1:0] h;
        h = $urandom;
        case ($urandom_range(0, 4))
            0: ;
            1: h[IDX_W-1:0] = '0;
            2: h[IDX_W-1:0] = IDX_W'($urandom_range(SLOTS, (1 << IDX_W) - 1));
            3: begin
                if (live_handles.size() > 0) begin
                    h = live_handles[$urandom_range(0, live_handles.size() - 1)];
                    h[IDX_W + $urandom_range(0, CNT_W - 1)] ^= 1'b1;
                end
            end
            default: h[IDX_W-1:0] = IDX_W'($urandom_range(1, SLOTS - 1));
        endcase
        return h;
    endfunction

    function automatic logic [WORD_W-1:0] pick_handle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 75 && live_handles.size() > 0)
            return live_handles[$urandom_range(0, live_handles.size() - 1)];
        if (r < 87 && dead_handles.size() > 0)
            return dead_handles[$urandom_range(0, dead_handles.size() - 1)];
        return noise_handle();
    endfunction

    function automatic void retire_handle(input logic [WORD_W-1:0] h);
        dead_handles.push_back(h);
        if (dead_handles.size() > DEAD_KEEP) void'(dead_handles.pop_front());
    endfunction

    // Called at a falling edge; returns at a falling edge once the word is taken.
    // With pause set, valid drops right after, otherwise bursts and gaps apply.
    task automatic send_word(input logic [ACT_W-1:0] act, input logic [WORD_W-1:0] h,
                             input logic [WORD_W-1:0] uw, input bit pause);
        int gap;
        req_ch.valid     <= 1'b1;
        req_ch.action    <= act;
        req_ch.handle_in <= h;
        req_ch.user_word <= uw;
        do @(posedge i_clk); while (req_ch.ready !== 1'b1);
        @(negedge i_clk);
        if (pause) begin
            req_ch.valid <= 1'b0;
        end else if (burst_left > 0) begin
            burst_left--;
        end else begin
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(0, 15);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
            if (gap > 0) begin
                req_ch.valid     <= 1'b0;
                req_ch.action    <= ACT_W'($urandom);
                req_ch.handle_in <= $urandom;
                req_ch.user_word <= $urandom;
                repeat (gap) @(negedge i_clk);
            end
        end
    endtask

    task automatic random_request(input int create_pct, input int close_pct, input bit pause);
        int                r;
        int                k;
        logic [WORD_W-1:0] h;
        r = $urandom_range(0, 99);
        if (r < create_pct) begin
            send_word(ACT_CREATE, $urandom, $urandom, pause);
        end else if (r < create_pct + close_pct) begin
            if (live_handles.size() > 0 && $urandom_range(0, 9) != 0) begin
                k = $urandom_range(0, live_handles.size() - 1);
                h = live_handles[k];
                live_handles.delete(k);
                retire_handle(h);
            end else begin
                h = pick_handle();
            end
            send_word(ACT_CLOSE, h, $urandom, pause);
        end else begin
            r = $urandom_range(0, 19);
            if (r < 6)
                send_word(ACT_GET, pick_handle(), $urandom, pause);
            else if (r < 12)
                send_word(ACT_SET, pick_handle(), $urandom, pause);
            else if (r < 18)
                send_word(ACT_CHECK, pick_handle(), $urandom, pause);
            else
                send_word(ACT_W'($urandom_range(ACT_RSVD_FIRST, ACT_RSVD_LAST)),
                          pick_handle(), $urandom, pause);
        end
    endtask

    initial begin
        int                n;
        int                fill_n;
        logic [WORD_W-1:0] h;

        i_rst_n          = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.action    = ACT_CREATE;
        req_ch.handle_in = '0;
        req_ch.user_word = '0;
        rsp_ch.ready     = 1'b0;
        burst_left       = $urandom_range(0, 15);
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: reserved index, free slot, extremes, unused codes, stale handles
        send_word(ACT_CHECK,  '0,                       '0,            1'b0);
        send_word(ACT_GET,    make_handle(0, 1),        '1,            1'b0);
        send_word(ACT_CREATE, '1,                       '0,            1'b0);
        send_word(ACT_CREATE, '0,                       '1,            1'b0);
        send_word(ACT_GET,    make_handle(1, 1),        '0,            1'b0);
        send_word(ACT_GET,    make_handle(1, 2),        '0,            1'b0);
        send_word(ACT_SET,    make_handle(1, 1),        32'hA5A5_5A5A, 1'b0);
        send_word(ACT_GET,    make_handle(1, 1),        '0,            1'b0);
        send_word(ACT_CHECK,  make_handle(2, 1),        '0,            1'b0);
        send_word(ACT_CHECK,  make_handle(1, SLOTS),    '0,            1'b0);
        send_word(ACT_CHECK,  '1,                       '0,            1'b0);
        send_word(ACT_SET,    make_handle(1, 0),        '1,            1'b0);
        send_word(ACT_CLOSE,  make_handle(1, SLOTS - 1), '0,           1'b0);
        for (int c = ACT_RSVD_FIRST; c <= ACT_RSVD_LAST; c++)
            send_word(ACT_W'(c), make_handle(1, 1), $urandom, 1'b0);
        send_word(ACT_CLOSE,  make_handle(1, 1),        '0,            1'b0);
        send_word(ACT_GET,    make_handle(1, 1),        '0,            1'b0);
        send_word(ACT_CLOSE,  make_handle(1, 1),        '0,            1'b0);
        send_word(ACT_SET,    make_handle(1, 1),        '1,            1'b0);
        send_word(ACT_CREATE, '0,                       32'h1234_5678, 1'b0);
        send_word(ACT_CHECK,  make_handle(2, 1),        '0,            1'b0);
        send_word(ACT_CLOSE,  make_handle(1, 2),        '0,            1'b0);
        send_word(ACT_CHECK,  make_handle(1, 2),        '0,            1'b0);
        retire_handle(make_handle(1, 1));
        retire_handle(make_handle(1, 2));

        // slot reuse: the free list is LIFO, so create/close keeps hitting one slot
        for (int i = 0; i < 24; i++) begin
            n = live_handles.size();
            send_word(ACT_CREATE, $urandom, $urandom, 1'b1);
            while (live_handles.size() <= n) @(negedge i_clk);
            h = live_handles.pop_back();
            if (i % 1024 == 3) retire_handle(h);
            send_word(ACT_CLOSE, h, $urandom, 1'b0);
        end

        for (int i = 0; i < 100; i++) random_request(30, 15, i == 99);

        // fill the table past full, then drain it
        while (table_pending != 0) @(negedge i_clk);
        fill_n = SLOTS - 1 - live_handles.size() + 12;
        for (int i = 0; i < fill_n; i++) begin
            if ($urandom_range(0, 9) == 0)
                send_word(ACT_GET, pick_handle(), $urandom, 1'b0);
            send_word(ACT_CREATE, $urandom, $urandom, 1'b0);
        end
        for (int i = 0; i < 120; i++) random_request(10, 45, 1'b0);
        for (int i = 0; i < 50; i++) random_request(30, 25, i == 49);

        while (table_pending != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fail_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
